// ===== sv/sctp_connection_tracker_macros.svh =====
// assertion macros for the sctp connection tracker
`ifndef SCTP_CONNECTION_TRACKER_MACROS_SVH
`define SCTP_CONNECTION_TRACKER_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SCT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sctp tracker check failed");

// next-cycle implication, clocked on i_clk, off during reset
`define SCT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sctp tracker check failed");

`endif

// ===== sv/sct_pkg.sv =====
// types, constants and chunk decode for the sctp connection tracker
`timescale 1ns / 1ps

package sct_pkg;

    localparam int TAG_W     = 32;
    localparam int TMO_W     = 16;
    localparam int SEEN_W    = 10;
    localparam int TFLAG_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [TMO_W-1:0] OPEN_WAIT_TMO_RST   = 16'd3;
    localparam logic [TMO_W-1:0] ESTABLISHED_TMO_RST = 16'd210;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_WAIT_TMO   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESTABLISHED_TMO = 2'd1;

    // chunk type numbers
    localparam logic [7:0] CT_DATA        = 8'd0;
    localparam logic [7:0] CT_INIT        = 8'd1;
    localparam logic [7:0] CT_INIT_ACK    = 8'd2;
    localparam logic [7:0] CT_HB          = 8'd4;
    localparam logic [7:0] CT_HB_ACK      = 8'd5;
    localparam logic [7:0] CT_ABORT       = 8'd6;
    localparam logic [7:0] CT_SHUT_ACK    = 8'd8;
    localparam logic [7:0] CT_COOKIE_ECHO = 8'd10;
    localparam logic [7:0] CT_COOKIE_ACK  = 8'd11;
    localparam logic [7:0] CT_SHUT_COMP   = 8'd14;

    // bit positions in the seen mask
    localparam int B_DATA        = 0;
    localparam int B_INIT        = 1;
    localparam int B_INIT_ACK    = 2;
    localparam int B_HB          = 3;
    localparam int B_HB_ACK      = 4;
    localparam int B_ABORT       = 5;
    localparam int B_SHUT_ACK    = 6;
    localparam int B_COOKIE_ECHO = 7;
    localparam int B_COOKIE_ACK  = 8;
    localparam int B_SHUT_COMP   = 9;

    // bit positions in the t flag mask
    localparam int T_ABORT     = 0;
    localparam int T_SHUT_COMP = 1;

    typedef enum logic [1:0] {
        ST_NONE        = 2'd0,
        ST_OPEN_WAIT   = 2'd1,
        ST_ESTABLISHED = 2'd2
    } t_track_state;

    typedef struct packed {
        logic             direction;
        logic             new_entry;
        logic             header_bad;
        logic [TAG_W-1:0] packet_vtag;
        logic             chunk_present;
        logic [7:0]       chunk_type;
        logic             chunk_t_flag;
        logic [TAG_W-1:0] initiate_tag;
        logic             initiate_ok;
        logic             last_chunk;
    } t_chunk_in;

    typedef struct packed {
        logic             verdict;
        logic             refresh;
        logic [TMO_W-1:0] timeout_seconds;
        logic [1:0]       state_after;
        logic             protoinfo_event;
        logic             assured_event;
    } t_verdict_out;

    // one-hot seen-mask bit of a tracked chunk type, zero when untracked
    function automatic logic [SEEN_W-1:0] type_mask(input logic [7:0] ctype);
        logic [SEEN_W-1:0] m;
        m = '0;
        case (ctype)
            CT_DATA:        m[B_DATA]        = 1'b1;
            CT_INIT:        m[B_INIT]        = 1'b1;
            CT_INIT_ACK:    m[B_INIT_ACK]    = 1'b1;
            CT_HB:          m[B_HB]          = 1'b1;
            CT_HB_ACK:      m[B_HB_ACK]      = 1'b1;
            CT_ABORT:       m[B_ABORT]       = 1'b1;
            CT_SHUT_ACK:    m[B_SHUT_ACK]    = 1'b1;
            CT_COOKIE_ECHO: m[B_COOKIE_ECHO] = 1'b1;
            CT_COOKIE_ACK:  m[B_COOKIE_ACK]  = 1'b1;
            CT_SHUT_COMP:   m[B_SHUT_COMP]   = 1'b1;
            default:        m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== sv/sctp_connection_tracker.sv =====
// sctp connection tracker: per-chunk mask collection and per-packet verdict
//
// chunks of one packet arrive on the input channel, one per transfer, the
// last one flagged by last_chunk; a transfer with chunk_present low only
// closes the packet. each packet yields exactly one result transfer on the
// output channel, carrying verdict, timer refresh, timeout, state and events.
// an item is accepted into an input register and judged from it against the
// association state; a final chunk's result is then written to the output
// register once that register frees. one chunk is accepted every cycle while
// no final chunk waits; the combinational judge stage sets this.
// when the receiver stalls, the output register holds its result and the
// judge stage still takes non-final chunks; a final chunk waits in the input
// register, with input ready low, until the output register frees.
// timeouts are to be written on the configuration port only while the block is idle; the block does not enforce this.
// synchronous active-low reset clears association state, packet masks and
// both valid flags, and loads the timeouts with 3 and 210 seconds.
`timescale 1ns / 1ps
`include "sctp_connection_tracker_macros.svh"

module sctp_connection_tracker
    import sct_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TMO_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_chunk_in            i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_verdict_out         o_out_data
);

    logic [TMO_W-1:0]   r_ow_tmo;
    logic [TMO_W-1:0]   r_est_tmo;

    logic               r_in_valid;
    t_chunk_in          r_in;

    t_track_state       r_state,        n_state;
    logic [TAG_W-1:0]   r_vtag_orig,    n_vtag_orig;
    logic [TAG_W-1:0]   r_vtag_reply,   n_vtag_reply;
    logic               r_hb_failed,    n_hb_failed;
    logic               r_last_dir,     n_last_dir;
    logic               r_assured,      n_assured;
    logic [SEEN_W-1:0]  r_seen,         n_seen;
    logic [TFLAG_W-1:0] r_tflag,        n_tflag;
    logic [TAG_W-1:0]   r_itag,         n_itag;
    logic               r_pkt_bad,      n_pkt_bad;

    logic               r_out_valid;
    t_verdict_out       r_out,          n_out;

    logic               out_free;
    logic               s2_go;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s2_go      = r_in_valid && (!r_in.last_chunk || out_free);
    assign o_in_ready = !r_in_valid || s2_go;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ow_tmo  <= OPEN_WAIT_TMO_RST;
            r_est_tmo <= ESTABLISHED_TMO_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OPEN_WAIT_TMO:   r_ow_tmo  <= i_cfg_wdata;
                CFG_ESTABLISHED_TMO: r_est_tmo <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // judge stage
    always_comb begin
        logic [SEEN_W-1:0]  s;
        logic [TFLAG_W-1:0] tf;
        logic               is_init;
        logic               dir;
        logic [TAG_W-1:0]   vt;
        logic [TAG_W-1:0]   tag_o;
        logic [TAG_W-1:0]   tag_r;
        logic [TAG_W-1:0]   tag_d;
        logic [TAG_W-1:0]   tag_x;
        logic               mism;
        logic               bad;
        logic               refresh;
        logic               ev_p;
        logic               ev_a;
        logic               hb_ok;
        logic               tc_ok;

        s       = r_seen;
        tf      = r_tflag;
        is_init = (r_in.chunk_type == CT_INIT) || (r_in.chunk_type == CT_INIT_ACK);
        n_itag    = r_itag;
        n_pkt_bad = r_pkt_bad | r_in.header_bad;
        if (r_in.chunk_present) begin
            s = s | type_mask(r_in.chunk_type);
            if (r_in.chunk_t_flag && r_in.chunk_type == CT_ABORT) begin
                tf[T_ABORT] = 1'b1;
            end
            if (r_in.chunk_t_flag && r_in.chunk_type == CT_SHUT_COMP) begin
                tf[T_SHUT_COMP] = 1'b1;
            end
            if (is_init) begin
                if (r_in.initiate_ok) begin
                    n_itag = r_in.initiate_tag;
                end else begin
                    n_pkt_bad = 1'b1;
                end
            end
        end

        dir     = r_in.direction;
        vt      = r_in.packet_vtag;
        tag_o   = r_vtag_orig;
        tag_r   = r_vtag_reply;
        n_state     = r_state;
        n_hb_failed = r_hb_failed;
        n_last_dir  = r_last_dir;
        n_assured   = r_assured;
        bad     = n_pkt_bad;
        refresh = 1'b0;
        ev_p    = 1'b0;
        ev_a    = 1'b0;
        hb_ok   = 1'b1;
        tc_ok   = 1'b1;
        tag_d   = '0;
        tag_x   = '0;
        mism    = 1'b0;

        if (!bad) begin
            if (r_in.new_entry) begin
                if (s[B_ABORT] || s[B_SHUT_COMP] || s[B_COOKIE_ACK]) begin
                    bad = 1'b1;
                end else begin
                    tag_o       = '0;
                    tag_r       = '0;
                    n_hb_failed = 1'b0;
                    n_last_dir  = 1'b0;
                    n_assured   = 1'b0;
                    n_state     = ST_OPEN_WAIT;
                    ev_p        = 1'b1;
                    if (s[B_INIT]) begin
                        if (dir) tag_o = n_itag; else tag_r = n_itag;
                    end else if (s[B_SHUT_ACK]) begin
                        if (dir) tag_o = vt; else tag_r = vt;
                    end else begin
                        if (dir) tag_r = vt; else tag_o = vt;
                    end
                    refresh = 1'b1;
                end
            end else if (!s[B_INIT]) begin
                // learn missing tags
                tag_x = dir ? tag_o : tag_r;
                if (tag_x == '0 && s[B_INIT_ACK]) begin
                    if (dir) tag_o = n_itag; else tag_r = n_itag;
                end
                tag_d = dir ? tag_r : tag_o;
                if (tag_d == '0) begin
                    if (dir) tag_r = vt; else tag_o = vt;
                end
                if (dir && r_state == ST_OPEN_WAIT) begin
                    n_state = ST_ESTABLISHED;
                    ev_p    = 1'b1;
                    if (!r_assured) begin
                        n_assured = 1'b1;
                        ev_a      = 1'b1;
                    end
                end
                // heartbeat tag-change logic
                tag_d = dir ? tag_r : tag_o;
                mism  = (vt != tag_d);
                if (s[B_HB]) begin
                    if (mism) begin
                        if (s[B_DATA]) begin
                            hb_ok = 1'b0;
                        end else begin
                            n_hb_failed = 1'b1;
                            n_last_dir  = dir;
                        end
                    end else begin
                        n_hb_failed = 1'b0;
                    end
                end
                if (hb_ok && s[B_HB_ACK]) begin
                    if (mism) begin
                        if (s[B_DATA] || !n_hb_failed || n_last_dir == dir) begin
                            hb_ok = 1'b0;
                        end else begin
                            n_hb_failed = 1'b0;
                            if (dir) begin
                                tag_r = vt;
                                tag_o = '0;
                            end else begin
                                tag_o = vt;
                                tag_r = '0;
                            end
                        end
                    end else begin
                        n_hb_failed = 1'b0;
                    end
                end
                // verification tag checks
                tag_d = dir ? tag_r : tag_o;
                tag_x = dir ? tag_o : tag_r;
                if (!s[B_INIT] && !s[B_SHUT_COMP] && !s[B_COOKIE_ECHO] && !s[B_ABORT] &&
                    !s[B_SHUT_ACK] && !s[B_HB] && !s[B_HB_ACK] && vt != tag_d) begin
                    tc_ok = 1'b0;
                end
                if (s[B_ABORT] && vt != (tf[T_ABORT] ? tag_x : tag_d)) begin
                    tc_ok = 1'b0;
                end
                if (s[B_SHUT_COMP] && vt != (tf[T_SHUT_COMP] ? tag_x : tag_d)) begin
                    tc_ok = 1'b0;
                end
                if (s[B_COOKIE_ECHO] && vt != tag_d) begin
                    tc_ok = 1'b0;
                end
                if (!hb_ok || !tc_ok) begin
                    bad = 1'b1;
                end else begin
                    refresh = 1'b1;
                end
            end
        end

        n_vtag_orig  = tag_o;
        n_vtag_reply = tag_r;
        n_seen       = s;
        n_tflag      = tf;

        n_out.verdict         = bad;
        n_out.refresh         = refresh;
        n_out.timeout_seconds = !refresh ? '0 :
                                (n_state == ST_ESTABLISHED) ? r_est_tmo : r_ow_tmo;
        n_out.state_after     = n_state;
        n_out.protoinfo_event = ev_p;
        n_out.assured_event   = ev_a;
    end

    // association state and packet masks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_NONE;
            r_vtag_orig  <= '0;
            r_vtag_reply <= '0;
            r_hb_failed  <= 1'b0;
            r_last_dir   <= 1'b0;
            r_assured    <= 1'b0;
            r_seen       <= '0;
            r_tflag      <= '0;
            r_itag       <= '0;
            r_pkt_bad    <= 1'b0;
        end else if (s2_go) begin
            if (r_in.last_chunk) begin
                r_state      <= n_state;
                r_vtag_orig  <= n_vtag_orig;
                r_vtag_reply <= n_vtag_reply;
                r_hb_failed  <= n_hb_failed;
                r_last_dir   <= n_last_dir;
                r_assured    <= n_assured;
                r_seen       <= '0;
                r_tflag      <= '0;
                r_itag       <= '0;
                r_pkt_bad    <= 1'b0;
            end else begin
                r_seen       <= n_seen;
                r_tflag      <= n_tflag;
                r_itag       <= n_itag;
                r_pkt_bad    <= n_pkt_bad;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_go && r_in.last_chunk) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go && r_in.last_chunk) begin
            r_out <= n_out;
        end
    end

    `SCT_ASSERT_IMP(a_bad_no_refresh, r_out_valid && r_out.verdict,
        !r_out.refresh && r_out.timeout_seconds == '0)
    `SCT_ASSERT_IMP(a_assured_established, r_out_valid && r_out.assured_event,
        r_out.protoinfo_event && r_out.state_after == ST_ESTABLISHED)
    `SCT_ASSERT_NXT(a_masks_cleared, s2_go && r_in.last_chunk,
        r_seen == '0 && r_tflag == '0 && !r_pkt_bad)
    `SCT_ASSERT_NXT(a_result_follows_last, s2_go && r_in.last_chunk, r_out_valid)

endmodule
